>>> src/fpe_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fpe_pkg: shared types, constants and rounding functions
// Binary32 constants, the sideband record carried beside each operation and
// the normalize/round helpers used by the multiply and add units.
// ----------------------------------------------------------------------------
package fpe_pkg;

	localparam logic [31:0] K_MAGIC     = 32'h4B40_0000;
	localparam logic [31:0] K_NEG_MAGIC = 32'hCB40_0000;
	localparam logic [31:0] K_ZERO_MAG  = 32'h42CF_F1B4;
	localparam logic [31:0] K_INF_CUT   = 32'h42B1_7217;
	localparam logic [31:0] K_LOG2E     = 32'h3FB8_AA3B;
	localparam logic [31:0] K_NLN2_HI   = 32'hBF31_7200;
	localparam logic [31:0] K_NLN2_LO   = 32'hB5BF_BE8E;
	localparam logic [31:0] K_C1        = 32'h3F7F_FFFB;
	localparam logic [31:0] K_C2        = 32'h3EFF_FEE3;
	localparam logic [31:0] K_C3        = 32'h3E2A_AD40;
	localparam logic [31:0] K_C4        = 32'h3D2B_9D0D;
	localparam logic [31:0] K_C5        = 32'h3C07_CFCE;
	localparam logic [31:0] K_EXP_MIN   = 32'hC100_0000;
	localparam logic [31:0] K_EXP_MAX   = 32'h3F80_0000;
	localparam logic [31:0] K_ONE       = 32'h3F80_0000;
	localparam logic [31:0] K_DEF_NAN   = 32'hFFC0_0000;
	localparam logic [31:0] K_INF       = 32'h7F80_0000;
	localparam logic [31:0] K_QUIET     = 32'h0040_0000;

	typedef struct packed {
		logic [31:0] x;
		logic [31:0] sn;
		logic [31:0] so;
		logic [31:0] aux;
		logic        last;
	} side_t;

	function automatic logic is_nan(input logic [31:0] v);
		is_nan = (v[30:0] > K_INF[30:0]);
	endfunction

	function automatic logic is_inf(input logic [31:0] v);
		is_inf = (v[30:0] == K_INF[30:0]);
	endfunction

	function automatic logic is_zero(input logic [31:0] v);
		is_zero = (v[30:0] == 31'd0);
	endfunction

	// sig has its leading bit at 30; exp is the biased exponent minus one
	function automatic logic [31:0] round_pack(input logic sign,
			input logic signed [11:0] exp, input logic [30:0] sig);
		logic [31:0]        s;
		logic signed [11:0] e;
		logic [11:0]        nsh;
		logic [31:0]        mask;
		logic [6:0]         rb;
		logic [31:0]        s2;
		logic               ovf;
		s    = {1'b0, sig};
		e    = exp;
		ovf  = 1'b0;
		nsh  = 12'd0;
		mask = 32'd0;
		if (e < 12'sd0) begin
			nsh = 12'(-e);
			if (nsh >= 12'd31) begin
				s = {31'd0, |s};
			end else begin
				mask = (32'd1 << nsh[4:0]) - 32'd1;
				s    = (s >> nsh[4:0]) | {31'd0, |(s & mask)};
			end
			e = 12'sd0;
		end else if (e > 12'sd253 ||
				(e == 12'sd253 && (s + 32'h40) >= 32'h8000_0000)) begin
			ovf = 1'b1;
		end
		rb = s[6:0];
		s2 = (s + 32'h40) >> 7;
		if (rb == 7'h40) begin
			s2[0] = 1'b0;
		end
		if (s2 == 32'd0) begin
			e = 12'sd0;
		end
		if (ovf) begin
			round_pack = {sign, K_INF[30:0]};
		end else begin
			round_pack = {sign, 31'd0} + {1'b0, e[7:0], 23'd0} + s2;
		end
	endfunction

	// rounds the nonzero value m * 2^k
	function automatic logic [31:0] norm_round(input logic sign,
			input logic signed [11:0] k, input logic [62:0] m);
		logic [5:0]         h;
		logic [5:0]         s;
		logic [62:0]        mm;
		logic [30:0]        sig;
		logic signed [11:0] e;
		h = 6'd0;
		for (int i = 0; i < 63; i++) begin
			if (m[i]) begin
				h = 6'(i);
			end
		end
		s   = 6'd62 - h;
		mm  = m << s;
		sig = mm[62:32] | {30'd0, |mm[31:0]};
		e   = k - $signed({6'd0, s}) + 12'sd188;
		norm_round = round_pack(sign, e, sig);
	endfunction

endpackage
`default_nettype wire

>>> src/fpe_fmul.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fpe_fmul: pipelined binary32 multiplier
// Two stages: special cases and significand product, then normalize and
// round to nearest even. Sideband record travels beside the operands.
// ----------------------------------------------------------------------------
module fpe_fmul (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          en,
	input  wire logic          in_valid,
	input  wire logic [31:0]   a,
	input  wire logic [31:0]   b,
	input  wire fpe_pkg::side_t side_in,
	output logic               out_valid,
	output logic [31:0]        r,
	output fpe_pkg::side_t     side_out
);
	import fpe_pkg::*;

	logic               sign;
	logic               spec;
	logic [31:0]        spec_val;
	logic [23:0]        sa;
	logic [23:0]        sb;
	logic [7:0]         ea;
	logic [7:0]         eb;

	logic               v_s1;
	logic               sign_s1;
	logic               spec_s1;
	logic [31:0]        spec_val_s1;
	logic signed [11:0] k_s1;
	logic [47:0]        prod_s1;
	side_t              side_s1;

	logic               v_s2;
	logic [31:0]        r_s2;
	side_t              side_s2;

	always_comb begin
		sign     = a[31] ^ b[31];
		spec     = 1'b1;
		spec_val = 32'd0;
		if (is_nan(a)) begin
			spec_val = a | K_QUIET;
		end else if (is_nan(b)) begin
			spec_val = b | K_QUIET;
		end else if (is_inf(a) || is_inf(b)) begin
			spec_val = (is_zero(a) || is_zero(b)) ? K_DEF_NAN : {sign, K_INF[30:0]};
		end else if (is_zero(a) || is_zero(b)) begin
			spec_val = {sign, 31'd0};
		end else begin
			spec = 1'b0;
		end
		sa = {|a[30:23], a[22:0]};
		sb = {|b[30:23], b[22:0]};
		ea = (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
		eb = (b[30:23] == 8'd0) ? 8'd1 : b[30:23];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sign_s1     <= sign;
			spec_s1     <= spec;
			spec_val_s1 <= spec_val;
			k_s1        <= $signed({4'd0, ea}) + $signed({4'd0, eb}) - 12'sd300;
			prod_s1     <= sa * sb;
			side_s1     <= side_in;
			r_s2        <= spec_s1 ? spec_val_s1
				: norm_round(sign_s1, k_s1, {15'd0, prod_s1});
			side_s2     <= side_s1;
		end
	end

	assign out_valid = v_s2;
	assign r         = r_s2;
	assign side_out  = side_s2;

endmodule
`default_nettype wire

>>> src/fpe_fadd.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fpe_fadd: pipelined binary32 adder
// Three stages: special cases and alignment, significand add or subtract,
// then normalize and round to nearest even.
// ----------------------------------------------------------------------------
module fpe_fadd (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          en,
	input  wire logic          in_valid,
	input  wire logic [31:0]   a,
	input  wire logic [31:0]   b,
	input  wire fpe_pkg::side_t side_in,
	output logic               out_valid,
	output logic [31:0]        r,
	output fpe_pkg::side_t     side_out
);
	import fpe_pkg::*;

	logic        spec;
	logic [31:0] spec_val;
	logic [7:0]  ea_a;
	logic [7:0]  eb_b;
	logic [55:0] big_a;
	logic [55:0] big_b;
	logic        swap;
	logic [55:0] hi_sig;
	logic [55:0] lo_sig;
	logic [7:0]  hi_exp;
	logic        hi_sgn;
	logic        lo_sgn;
	logic [7:0]  d;
	logic [55:0] mask;
	logic [55:0] lo_al;

	logic        v_s1;
	logic        spec_s1;
	logic [31:0] spec_val_s1;
	logic [55:0] hi_s1;
	logic [55:0] lo_s1;
	logic [7:0]  exp_s1;
	logic        hsg_s1;
	logic        lsg_s1;
	side_t       side_s1;

	logic        v_s2;
	logic        spec_s2;
	logic [31:0] spec_val_s2;
	logic [56:0] m_s2;
	logic        sign_s2;
	logic [7:0]  exp_s2;
	side_t       side_s2;

	logic        v_s3;
	logic [31:0] r_s3;
	side_t       side_s3;

	logic [56:0] m_sum;
	logic        m_sign;

	always_comb begin
		spec     = 1'b1;
		spec_val = 32'd0;
		if (is_nan(a)) begin
			spec_val = a | K_QUIET;
		end else if (is_nan(b)) begin
			spec_val = b | K_QUIET;
		end else if (is_inf(a) && is_inf(b)) begin
			spec_val = (a[31] == b[31]) ? a : K_DEF_NAN;
		end else if (is_inf(a)) begin
			spec_val = a;
		end else if (is_inf(b)) begin
			spec_val = b;
		end else if (is_zero(a) && is_zero(b)) begin
			spec_val = {a[31] & b[31], 31'd0};
		end else if (is_zero(a)) begin
			spec_val = b;
		end else if (is_zero(b)) begin
			spec_val = a;
		end else begin
			spec = 1'b0;
		end
		ea_a  = (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
		eb_b  = (b[30:23] == 8'd0) ? 8'd1 : b[30:23];
		big_a = {8'd0, |a[30:23], a[22:0], 24'd0} << 8;
		big_b = {8'd0, |b[30:23], b[22:0], 24'd0} << 8;
		swap  = (ea_a < eb_b);
		hi_sig = swap ? big_b : big_a;
		lo_sig = swap ? big_a : big_b;
		hi_exp = swap ? eb_b : ea_a;
		hi_sgn = swap ? b[31] : a[31];
		lo_sgn = swap ? a[31] : b[31];
		d      = hi_exp - (swap ? ea_a : eb_b);
		mask   = 56'd0;
		if (d >= 8'd63) begin
			lo_al = {55'd0, |lo_sig};
		end else begin
			mask  = (56'd1 << d[5:0]) - 56'd1;
			lo_al = (lo_sig >> d[5:0]) | {55'd0, |(lo_sig & mask)};
		end
	end

	always_comb begin
		if (hsg_s1 == lsg_s1) begin
			m_sum  = {1'b0, hi_s1} + {1'b0, lo_s1};
			m_sign = hsg_s1;
		end else if (hi_s1 >= lo_s1) begin
			m_sum  = {1'b0, hi_s1 - lo_s1};
			m_sign = hsg_s1;
		end else begin
			m_sum  = {1'b0, lo_s1 - hi_s1};
			m_sign = lsg_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			spec_s1     <= spec;
			spec_val_s1 <= spec_val;
			hi_s1       <= hi_sig;
			lo_s1       <= lo_al;
			exp_s1      <= hi_exp;
			hsg_s1      <= hi_sgn;
			lsg_s1      <= lo_sgn;
			side_s1     <= side_in;

			spec_s2     <= spec_s1;
			spec_val_s2 <= spec_val_s1;
			m_s2        <= m_sum;
			sign_s2     <= m_sign;
			exp_s2      <= exp_s1;
			side_s2     <= side_s1;

			if (spec_s2) begin
				r_s3 <= spec_val_s2;
			end else if (m_s2 == 57'd0) begin
				r_s3 <= 32'd0;
			end else begin
				r_s3 <= norm_round(sign_s2, $signed({4'd0, exp_s2}) - 12'sd182,
					{6'd0, m_s2});
			end
			side_s3 <= side_s2;
		end
	end

	assign out_valid = v_s3;
	assign r         = r_s3;
	assign side_out  = side_s3;

endmodule
`default_nettype wire

>>> src/fp32_exp_poly5_unit_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fp32_exp_poly5_unit_core: pipelined binary32 exponential
// Range reduction, degree-5 polynomial and power-of-two rebuild as a chain
// of separately rounded multiply and add units.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid/in_ready carries x_bits (binary32 argument) and
//   last_in. Output channel out_valid/out_ready carries y_bits = exp(x) and
//   last_out, the unchanged copy of last_in. Results leave in input order.
//   Pipeline: ten multiplies of two stages, nine adds of three stages and
//   one output register lie between acceptance and out_valid.
//   Throughput: one transaction per cycle while in_ready is high; every stage
//   is one operation step and the chain holds 47 transactions in flight.
//   Reset: arst_n clears every valid bit; the pipeline comes up empty.
//   Receiver stall: the output register holds its transaction and a spare
//   register takes one more; while the spare is full the whole chain holds
//   and in_ready is low. Nothing is dropped or repeated.
// ----------------------------------------------------------------------------
module fp32_exp_poly5_unit_core (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [31:0] x_bits,
	input  wire logic        last_in,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [31:0]      y_bits,
	output logic             last_out
);
	import fpe_pkg::*;

	logic        pipe_en;
	logic [19:1] v;
	logic [31:0] r   [1:19];
	side_t       sd  [0:19];
	side_t       sd2b;
	side_t       sd3b;
	side_t       sd5b;
	side_t       sd7b;
	side_t       sd15b;

	logic [31:0] eo;
	logic [31:0] e_hi;
	logic [31:0] e_n;
	logic [31:0] f;
	logic [31:0] xv;

	logic        out_v_q;
	logic [31:0] out_y_q;
	logic        out_l_q;
	logic        spare_v_q;
	logic [31:0] spare_y_q;
	logic        spare_l_q;
	logic        take;
	logic        pop;

	assign pipe_en  = !spare_v_q;
	assign in_ready = pipe_en;

	always_comb begin
		sd[0]      = '0;
		sd[0].x    = x_bits;
		sd[0].last = last_in;
	end

	fpe_fmul u_op01 (.clk, .arst_n, .en(pipe_en), .in_valid(in_valid),
		.a(x_bits), .b(K_LOG2E), .side_in(sd[0]),
		.out_valid(v[1]), .r(r[1]), .side_out(sd[1]));
	fpe_fadd u_op02 (.clk, .arst_n, .en(pipe_en), .in_valid(v[1]),
		.a(r[1]), .b(K_MAGIC), .side_in(sd[1]),
		.out_valid(v[2]), .r(r[2]), .side_out(sd[2]));

	always_comb begin
		eo   = r[2] << 23;
		e_hi = ((eo ^ 32'h8000_0000) > (K_EXP_MIN ^ 32'h8000_0000)) ? eo : K_EXP_MIN;
		e_n  = ((e_hi ^ 32'h8000_0000) < (K_EXP_MAX ^ 32'h8000_0000)) ? e_hi : K_EXP_MAX;
		sd2b    = sd[2];
		sd2b.sn = e_n + K_ONE;
		sd2b.so = (eo - e_n) + K_ONE;
	end

	fpe_fadd u_op03 (.clk, .arst_n, .en(pipe_en), .in_valid(v[2]),
		.a(r[2]), .b(K_NEG_MAGIC), .side_in(sd2b),
		.out_valid(v[3]), .r(r[3]), .side_out(sd[3]));

	always_comb begin
		sd3b     = sd[3];
		sd3b.aux = r[3];
	end

	fpe_fmul u_op04 (.clk, .arst_n, .en(pipe_en), .in_valid(v[3]),
		.a(r[3]), .b(K_NLN2_HI), .side_in(sd3b),
		.out_valid(v[4]), .r(r[4]), .side_out(sd[4]));
	fpe_fadd u_op05 (.clk, .arst_n, .en(pipe_en), .in_valid(v[4]),
		.a(r[4]), .b(sd[4].x), .side_in(sd[4]),
		.out_valid(v[5]), .r(r[5]), .side_out(sd[5]));

	always_comb begin
		sd5b     = sd[5];
		sd5b.aux = r[5];
	end

	fpe_fmul u_op06 (.clk, .arst_n, .en(pipe_en), .in_valid(v[5]),
		.a(sd[5].aux), .b(K_NLN2_LO), .side_in(sd5b),
		.out_valid(v[6]), .r(r[6]), .side_out(sd[6]));
	fpe_fadd u_op07 (.clk, .arst_n, .en(pipe_en), .in_valid(v[6]),
		.a(r[6]), .b(sd[6].aux), .side_in(sd[6]),
		.out_valid(v[7]), .r(r[7]), .side_out(sd[7]));

	always_comb begin
		sd7b     = sd[7];
		sd7b.aux = r[7];
	end

	fpe_fmul u_op08 (.clk, .arst_n, .en(pipe_en), .in_valid(v[7]),
		.a(K_C5), .b(r[7]), .side_in(sd7b),
		.out_valid(v[8]), .r(r[8]), .side_out(sd[8]));
	fpe_fadd u_op09 (.clk, .arst_n, .en(pipe_en), .in_valid(v[8]),
		.a(r[8]), .b(K_C4), .side_in(sd[8]),
		.out_valid(v[9]), .r(r[9]), .side_out(sd[9]));
	fpe_fmul u_op10 (.clk, .arst_n, .en(pipe_en), .in_valid(v[9]),
		.a(r[9]), .b(sd[9].aux), .side_in(sd[9]),
		.out_valid(v[10]), .r(r[10]), .side_out(sd[10]));
	fpe_fadd u_op11 (.clk, .arst_n, .en(pipe_en), .in_valid(v[10]),
		.a(r[10]), .b(K_C3), .side_in(sd[10]),
		.out_valid(v[11]), .r(r[11]), .side_out(sd[11]));
	fpe_fmul u_op12 (.clk, .arst_n, .en(pipe_en), .in_valid(v[11]),
		.a(r[11]), .b(sd[11].aux), .side_in(sd[11]),
		.out_valid(v[12]), .r(r[12]), .side_out(sd[12]));
	fpe_fadd u_op13 (.clk, .arst_n, .en(pipe_en), .in_valid(v[12]),
		.a(r[12]), .b(K_C2), .side_in(sd[12]),
		.out_valid(v[13]), .r(r[13]), .side_out(sd[13]));
	fpe_fmul u_op14 (.clk, .arst_n, .en(pipe_en), .in_valid(v[13]),
		.a(r[13]), .b(sd[13].aux), .side_in(sd[13]),
		.out_valid(v[14]), .r(r[14]), .side_out(sd[14]));
	fpe_fadd u_op15 (.clk, .arst_n, .en(pipe_en), .in_valid(v[14]),
		.a(r[14]), .b(K_C1), .side_in(sd[14]),
		.out_valid(v[15]), .r(r[15]), .side_out(sd[15]));

	always_comb begin
		sd15b     = sd[15];
		sd15b.aux = r[15];
	end

	fpe_fmul u_op16 (.clk, .arst_n, .en(pipe_en), .in_valid(v[15]),
		.a(sd[15].aux), .b(sd[15].so), .side_in(sd15b),
		.out_valid(v[16]), .r(r[16]), .side_out(sd[16]));
	fpe_fmul u_op17 (.clk, .arst_n, .en(pipe_en), .in_valid(v[16]),
		.a(r[16]), .b(sd[16].aux), .side_in(sd[16]),
		.out_valid(v[17]), .r(r[17]), .side_out(sd[17]));
	fpe_fadd u_op18 (.clk, .arst_n, .en(pipe_en), .in_valid(v[17]),
		.a(r[17]), .b(sd[17].so), .side_in(sd[17]),
		.out_valid(v[18]), .r(r[18]), .side_out(sd[18]));
	fpe_fmul u_op19 (.clk, .arst_n, .en(pipe_en), .in_valid(v[18]),
		.a(sd[18].sn), .b(r[18]), .side_in(sd[18]),
		.out_valid(v[19]), .r(r[19]), .side_out(sd[19]));

	// force the cutoff results
	always_comb begin
		xv = sd[19].x;
		f  = r[19];
		if (xv[31] && xv[30:0] > K_ZERO_MAG[30:0] && xv[30:0] <= K_INF[30:0]) begin
			f = 32'd0;
		end
		if (!xv[31] && xv > K_INF_CUT && xv <= K_INF) begin
			f = K_INF;
		end
	end

	assign take = v[19] && pipe_en;
	assign pop  = out_v_q && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q   <= 1'b0;
			spare_v_q <= 1'b0;
		end else if (spare_v_q) begin
			if (pop) begin
				spare_v_q <= 1'b0;
			end
		end else if (!out_v_q || pop) begin
			out_v_q <= take;
		end else if (take) begin
			spare_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (spare_v_q) begin
			if (pop) begin
				out_y_q <= spare_y_q;
				out_l_q <= spare_l_q;
			end
		end else if (!out_v_q || pop) begin
			out_y_q <= f;
			out_l_q <= sd[19].last;
		end else begin
			spare_y_q <= f;
			spare_l_q <= sd[19].last;
		end
	end

	assign out_valid = out_v_q;
	assign y_bits    = out_y_q;
	assign last_out  = out_l_q;

`ifndef SYNTHESIS
	a_spare_needs_out: assert property (@(posedge clk) disable iff (!arst_n)
		spare_v_q |-> out_v_q)
		else $error("spare register full while output register empty");
	a_spare_fill: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(spare_v_q) |-> $past(out_v_q && !out_ready && v[19]))
		else $error("spare register filled without a stalled output");
	a_spare_drain: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(spare_v_q) |-> $past(out_ready) && out_v_q)
		else $error("spare register drained without an output transaction");
`endif

endmodule
`default_nettype wire
